@@ sv/lzss_pkg.sv @@
// ----------------------------------------------------------------------------
// lzss_pkg
// Shared constants and the command record of the LZSS stream decompressor.
// ----------------------------------------------------------------------------
`default_nettype none

package lzss_pkg;

  // History window geometry
  localparam int WINDOW_SIZE = 4096;
  localparam int WIN_W       = $clog2(WINDOW_SIZE);
  localparam int FILL_W      = WIN_W + 1;

  // Reset value of the start position register
  localparam logic [WIN_W-1:0] START_RESET = WIN_W'(12'hfee);

  // Match length code is biased by this amount
  localparam logic [4:0] MATCH_BIAS = 5'd3;

  // Command queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  // Command kinds
  localparam logic [1:0] CMD_LIT     = 2'd0;
  localparam logic [1:0] CMD_MATCH   = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  // One unit of work for the back end
  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       lit;
    logic [WIN_W-1:0] offset;
    logic [3:0]       len_code;
    logic             eos;
  } cmd_t;

endpackage

`default_nettype wire

@@ sv/lzss_ifs.sv @@
// ----------------------------------------------------------------------------
// lzss_ifs
// Valid/ready channel interfaces: compressed input, decompressed output and
// the start position write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface lzss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_stream;

  modport source (output valid, output in_byte, output end_of_stream, input ready);
  modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface lzss_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

interface lzss_cfg_if;
  logic        valid;
  logic        ready;
  logic [11:0] start_position;

  modport source (output valid, output start_position, input ready);
  modport sink   (input valid, input start_position, output ready);
endinterface

`default_nettype wire

@@ sv/lzss_front.sv @@
// ----------------------------------------------------------------------------
// lzss_front
// Token parser: accepts compressed bytes, tracks flag bits and turns each
// complete token into a command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lzss_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic [7:0]    in_byte,
  input  wire logic          in_eos,
  output logic               in_ready,
  input  wire logic          full,
  output logic               push,
  output lzss_pkg::cmd_t     push_cmd
);

  // Parser phases
  localparam logic [1:0] PH_FLAG  = 2'd0;
  localparam logic [1:0] PH_TOKEN = 2'd1;
  localparam logic [1:0] PH_HIGH  = 2'd2;

  logic [1:0] phase, phase_next;
  logic [7:0] flag_bits, flag_bits_next;
  logic [3:0] flag_index, flag_index_next;
  logic [7:0] saved_low, saved_low_next;
  logic       cmd_en;
  logic       accept;

  assign in_ready = !full;
  assign accept   = in_valid && !full;
  assign push     = accept && cmd_en;

  // Decode the incoming byte against the parser state
  always_comb begin
    logic [3:0] idx_inc;
    idx_inc         = flag_index + 4'd1;
    phase_next      = phase;
    flag_bits_next  = flag_bits;
    flag_index_next = flag_index;
    saved_low_next  = saved_low;
    cmd_en          = 1'b0;
    push_cmd.kind     = lzss_pkg::CMD_LIT;
    push_cmd.lit      = in_byte;
    push_cmd.offset   = {in_byte[7:4], saved_low};
    push_cmd.len_code = in_byte[3:0];
    push_cmd.eos      = in_eos;

    unique case (phase)
      PH_TOKEN: begin
        if (flag_bits[flag_index[2:0]]) begin
          cmd_en          = 1'b1;
          push_cmd.kind   = lzss_pkg::CMD_LIT;
          flag_index_next = idx_inc;
          phase_next      = idx_inc[3] ? PH_FLAG : PH_TOKEN;
        end else begin
          saved_low_next = in_byte;
          phase_next     = PH_HIGH;
        end
      end
      PH_HIGH: begin
        cmd_en          = 1'b1;
        push_cmd.kind   = lzss_pkg::CMD_MATCH;
        flag_index_next = idx_inc;
        phase_next      = idx_inc[3] ? PH_FLAG : PH_TOKEN;
      end
      default: begin
        // Flag byte; the unused phase code is parsed the same way
        flag_bits_next  = in_byte;
        flag_index_next = 4'd0;
        phase_next      = PH_TOKEN;
      end
    endcase

    // End of stream: drop a cut token, restart the window, reset the parser
    if (in_eos) begin
      if (!cmd_en) begin
        cmd_en        = 1'b1;
        push_cmd.kind = lzss_pkg::CMD_RESTART;
      end
      phase_next      = PH_FLAG;
      flag_bits_next  = 8'd0;
      flag_index_next = 4'd8;
      saved_low_next  = 8'd0;
    end
  end

  // Advance parser state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_FLAG;
      flag_bits  <= 8'd0;
      flag_index <= 4'd8;
      saved_low  <= 8'd0;
    end else if (accept) begin
      phase      <= phase_next;
      flag_bits  <= flag_bits_next;
      flag_index <= flag_index_next;
      saved_low  <= saved_low_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/lzss_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// lzss_cmd_fifo
// Short command queue that decouples the parser from the copy engine.
// ----------------------------------------------------------------------------
`default_nettype none

module lzss_cmd_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire lzss_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output lzss_pkg::cmd_t      head,
  output logic                empty
);

  lzss_pkg::cmd_t                slots [lzss_pkg::FIFO_DEPTH];
  logic [lzss_pkg::FIFO_AW-1:0]  wr_ptr;
  logic [lzss_pkg::FIFO_AW-1:0]  rd_ptr;
  logic [lzss_pkg::FIFO_CW-1:0]  count;
  logic                          do_push;
  logic                          do_pop;

  assign full    = (count == lzss_pkg::FIFO_CW'(lzss_pkg::FIFO_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Track pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/lzss_back.sv @@
// ----------------------------------------------------------------------------
// lzss_back
// Copy engine: issues window reads, writes every produced byte back into the
// 4096-byte history window and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lzss_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_valid,
  input  wire logic [lzss_pkg::WIN_W-1:0] cfg_data,
  output logic                            cfg_ready,
  input  wire logic                       cmd_empty,
  input  wire lzss_pkg::cmd_t             head,
  output logic                            pop,
  output logic                            out_valid,
  output logic [7:0]                      out_byte,
  output logic                            out_last,
  input  wire logic                       out_ready
);

  // Window memory and its registered read port
  logic [7:0] mem [lzss_pkg::WINDOW_SIZE];
  logic [7:0] rd_data;

  // Stream position state
  logic [lzss_pkg::WIN_W-1:0]  start_pos;
  logic [lzss_pkg::WIN_W-1:0]  wp;
  logic [lzss_pkg::WIN_W-1:0]  base;
  logic [lzss_pkg::FILL_W-1:0] fill;

  // Issue stage: current command
  logic                        cur_valid;
  logic [1:0]                  cur_kind;
  logic [7:0]                  cur_lit;
  logic [lzss_pkg::WIN_W-1:0]  cur_addr;
  logic [4:0]                  cur_cnt;
  logic                        cur_eos;

  // Write stage: one byte on its way to the window and the output
  logic                        w_valid;
  logic                        w_lit_src;
  logic [7:0]                  w_lit;
  logic                        w_fwd;
  logic [7:0]                  w_fwd_data;
  logic                        w_inwin;
  logic                        w_last;
  logic                        w_eos;
  logic [7:0]                  w_byte;

  logic                        out_free;
  logic                        w_fire;
  logic                        advance;
  logic                        issue;
  logic                        issue_last;
  logic                        rd_en;
  logic                        restart_now;
  logic [lzss_pkg::WIN_W-1:0]  rel;
  logic                        inwin_now;
  logic                        fwd_now;

  assign cfg_ready = 1'b1;

  // Handshake between stages
  assign out_free    = !out_valid || out_ready;
  assign w_fire      = w_valid && out_free;
  assign advance     = !w_valid || w_fire;
  assign issue       = cur_valid && advance;
  assign issue_last  = (cur_cnt == 5'd1);
  assign rd_en       = issue && (cur_kind == lzss_pkg::CMD_MATCH);
  assign pop         = !cur_valid && !cmd_empty && !(w_valid && w_eos);
  assign restart_now = (w_fire && w_eos) ||
                       (issue && (cur_kind == lzss_pkg::CMD_RESTART));

  // Written region starts at base and spans fill bytes
  assign rel       = cur_addr - base;
  assign inwin_now = fill[lzss_pkg::WIN_W] || ({1'b0, rel} < fill);
  // Read of the byte being written in this same cycle
  assign fwd_now   = w_fire && (cur_addr == wp);

  // Select the produced byte
  always_comb begin
    if (w_lit_src) begin
      w_byte = w_lit;
    end else if (w_fwd) begin
      w_byte = w_fwd_data;
    end else if (w_inwin) begin
      w_byte = rd_data;
    end else begin
      w_byte = 8'd0;
    end
  end

  // Window write and read ports
  always_ff @(posedge clk) begin
    if (w_fire) begin
      mem[wp] <= w_byte;
    end
    if (rd_en) begin
      rd_data <= mem[cur_addr];
    end
  end

  // Hold the start position register
  always_ff @(posedge clk) begin
    if (rst) begin
      start_pos <= lzss_pkg::START_RESET;
    end else if (cfg_valid) begin
      start_pos <= cfg_data;
    end
  end

  // Advance write position and fill count, restart at end of stream
  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= lzss_pkg::START_RESET;
      base <= lzss_pkg::START_RESET;
      fill <= '0;
    end else if (restart_now) begin
      wp   <= start_pos;
      base <= start_pos;
      fill <= '0;
    end else if (w_fire) begin
      wp <= wp + 1'b1;
      if (!fill[lzss_pkg::WIN_W]) begin
        fill <= fill + 1'b1;
      end
    end
  end

  // Load and step the current command
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (pop) begin
      cur_valid <= 1'b1;
    end else if (issue && issue_last) begin
      cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_kind <= head.kind;
      cur_lit  <= head.lit;
      cur_addr <= head.offset;
      cur_eos  <= head.eos;
      if (head.kind == lzss_pkg::CMD_MATCH) begin
        cur_cnt <= lzss_pkg::MATCH_BIAS + {1'b0, head.len_code};
      end else begin
        cur_cnt <= 5'd1;
      end
    end else if (issue) begin
      cur_addr <= cur_addr + 1'b1;
      cur_cnt  <= cur_cnt - 5'd1;
    end
  end

  // Write stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      w_valid <= 1'b0;
    end else if (advance) begin
      w_valid <= issue && (cur_kind != lzss_pkg::CMD_RESTART);
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      w_lit_src  <= (cur_kind == lzss_pkg::CMD_LIT);
      w_lit      <= cur_lit;
      w_fwd      <= fwd_now;
      w_fwd_data <= w_byte;
      w_inwin    <= inwin_now;
      w_last     <= issue_last;
      w_eos      <= cur_eos && issue_last;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= w_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (w_fire) begin
      out_byte <= w_byte;
      out_last <= w_last;
    end
  end

endmodule

`default_nettype wire

@@ sv/lzss_stream_decompressor_unit.sv @@
// ----------------------------------------------------------------------------
// lzss_stream_decompressor_unit
// LZSS decompressor with a 4096-byte history window, fed one compressed byte
// per transaction and producing one decompressed byte per transaction.
// ----------------------------------------------------------------------------
//
//   channel  | dir | payload                          | transaction
//   ---------+-----+----------------------------------+---------------------
//   stream   | in  | in_byte[7:0], end_of_stream      | one compressed byte
//   result   | out | out_byte[7:0], last_of_run       | one output byte
//   cfg      | in  | start_position[11:0]             | start position write
//
// Input bytes are taken at one per cycle while the four-entry command queue
// has room; flag bytes and match low bytes only update the parser.
// The copy engine loads a command and then produces its bytes one by one
// (one window read port); it loads the next command only after the last byte
// of the current one is issued. After the final byte of a stream the engine
// waits for the window restart; a token cut short by the end of stream
// produces no byte and only restarts the window.
// End of stream needs no clearing pass: a fill count marks written entries.
// Reset is synchronous; a result stall holds the engine, and a full queue
// drops stream.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module lzss_stream_decompressor_unit (
  input wire logic   clk,
  input wire logic   rst,
  lzss_in_if.sink    stream,
  lzss_out_if.source result,
  lzss_cfg_if.sink   cfg
);

  lzss_pkg::cmd_t push_cmd;
  lzss_pkg::cmd_t head;
  logic           push;
  logic           full;
  logic           pop;
  logic           empty;

  // Parse tokens
  lzss_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (stream.valid),
    .in_byte  (stream.in_byte),
    .in_eos   (stream.end_of_stream),
    .in_ready (stream.ready),
    .full     (full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Queue commands
  lzss_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  // Carry out commands against the window
  lzss_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg.valid),
    .cfg_data  (cfg.start_position),
    .cfg_ready (cfg.ready),
    .cmd_empty (empty),
    .head      (head),
    .pop       (pop),
    .out_valid (result.valid),
    .out_byte  (result.out_byte),
    .out_last  (result.last_of_run),
    .out_ready (result.ready)
  );

endmodule

`default_nettype wire

@@ sv/lzss_chk.sv @@
// ----------------------------------------------------------------------------
// lzss_chk
// Port-level checks for the LZSS stream decompressor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lzss_chk (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       stream_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       out_last
);

  // Reset empties the engine and the output register
  a_reset_no_result: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // Reset empties the command queue, so input is taken at once
  a_reset_ready: assert property (@(posedge clk) rst |=> stream_ready)
    else $error("stream not ready right after reset");

  // Hold a stalled result transaction
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind lzss_stream_decompressor_unit lzss_chk u_chk (
  .clk          (clk),
  .rst          (rst),
  .stream_ready (stream.ready),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .out_byte     (result.out_byte),
  .out_last     (result.last_of_run)
);

`default_nettype wire
